FILE: rtl/ihp_pkg.sv
// Shared types and constants for the IPv4 header probe.
// Used by every module under rtl/; depends on nothing.
package ihp_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 65535;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned L4_W = 8;

	localparam logic [LEN_W-1:0] ETH_HDR_BYTES = 16'd14;
	localparam logic [LEN_W-1:0] IPV4_MIN_FRAME = 16'd34;
	localparam logic [LEN_W-1:0] POS_ETYPE_HI = 16'd12;
	localparam logic [LEN_W-1:0] POS_ETYPE_LO = 16'd13;
	localparam logic [LEN_W-1:0] POS_IHL = 16'd14;
	localparam logic [LEN_W-1:0] POS_PROTO = 16'd23;
	localparam logic [LEN_W-1:0] POS_SRC_FIRST = 16'd26;
	localparam logic [LEN_W-1:0] POS_SRC_LAST = 16'd29;
	localparam logic [LEN_W-1:0] POS_DST_FIRST = 16'd30;
	localparam logic [LEN_W-1:0] POS_DST_LAST = 16'd33;
	localparam logic [LEN_W-1:0] POS_L4_MIN = 16'd34;
	localparam logic [L4_W-1:0] L4_BASE = 8'd14;
	localparam logic [L4_W-1:0] TCP_HDR_BYTES = 8'd20;
	localparam logic [L4_W-1:0] UDP_HDR_BYTES = 8'd8;
	localparam logic [L4_W-1:0] PORT_BYTES = 8'd4;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [3:0] IHL_MIN = 4'd5;
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// everything captured from one frame, handed over on its final byte
	typedef struct packed {
		logic [LEN_W-1:0] frame_len;
		logic [15:0] ether_type;
		logic [3:0] header_words;
		logic [7:0] ip_proto;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [31:0] port_bytes;
	} frame_sum_t;

	// first output field sits in the lowest bits; event_valid goes out on tuser
	typedef struct packed {
		logic [63:0] icmp_total;
		logic [63:0] udp_total;
		logic [63:0] tcp_total;
		logic [63:0] byte_total;
		logic [63:0] pkt_total;
		logic [15:0] pkt_len;
		logic [7:0] protocol;
		logic [15:0] dport;
		logic [15:0] sport;
		logic [31:0] dst_ip;
		logic [31:0] src_ip;
		logic event_valid;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);
	localparam int unsigned OUT_TDATA_W = ((RESULT_W - 1 + 7) / 8) * 8;

endpackage

FILE: rtl/ihp_capture.sv
// Byte capture stage: input register plus per-frame header capture.
// Depends on ihp_pkg; emits one frame summary per final byte.
module ihp_capture (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [7:0] in_byte,
	input  logic in_last,
	output logic last_pending,
	output logic sum_valid,
	output ihp_pkg::frame_sum_t sum
);

	logic valid_s1;
	logic last_s1;
	logic [7:0] byte_s1;

	logic [ihp_pkg::LEN_W-1:0] offset_q, offset_n;
	logic [15:0] etype_q, etype_n;
	logic [3:0] hw_q, hw_n;
	logic [7:0] proto_q, proto_n;
	logic [31:0] src_q, src_n;
	logic [31:0] dst_q, dst_n;
	logic [31:0] ports_q, ports_n;
	logic [ihp_pkg::L4_W-1:0] l4_off;
	logic [ihp_pkg::LEN_W-1:0] l4_pos;
	logic sum_valid_s2;
	ihp_pkg::frame_sum_t sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			last_s1 <= in_valid & in_last;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign l4_off = ihp_pkg::L4_BASE + {2'b00, hw_q, 2'b00};
	assign l4_pos = {{(ihp_pkg::LEN_W-ihp_pkg::L4_W){1'b0}}, l4_off};

	always_comb begin
		offset_n = offset_q;
		etype_n = etype_q;
		hw_n = hw_q;
		proto_n = proto_q;
		src_n = src_q;
		dst_n = dst_q;
		ports_n = ports_q;
		if (offset_q < ihp_pkg::LEN_W'(ihp_pkg::MAX_FRAME_BYTES)) begin
			offset_n = offset_q + 1'b1;
			if (offset_q == ihp_pkg::POS_ETYPE_HI || offset_q == ihp_pkg::POS_ETYPE_LO) begin
				etype_n = {etype_q[7:0], byte_s1};
			end
			if (offset_q == ihp_pkg::POS_IHL) begin
				hw_n = byte_s1[3:0];
			end
			if (offset_q == ihp_pkg::POS_PROTO) begin
				proto_n = byte_s1;
			end
			if (offset_q >= ihp_pkg::POS_SRC_FIRST && offset_q <= ihp_pkg::POS_SRC_LAST) begin
				src_n = {src_q[23:0], byte_s1};
			end
			if (offset_q >= ihp_pkg::POS_DST_FIRST && offset_q <= ihp_pkg::POS_DST_LAST) begin
				dst_n = {dst_q[23:0], byte_s1};
			end
			// first four L4 bytes hold the two ports
			if (offset_q >= ihp_pkg::POS_L4_MIN && offset_q >= l4_pos &&
				offset_q < l4_pos + ihp_pkg::LEN_W'(ihp_pkg::PORT_BYTES)) begin
				ports_n = {ports_q[23:0], byte_s1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			etype_q <= '0;
			hw_q <= '0;
			proto_q <= '0;
			src_q <= '0;
			dst_q <= '0;
			ports_q <= '0;
			sum_valid_s2 <= 1'b0;
		end else begin
			sum_valid_s2 <= valid_s1 & last_s1;
			if (valid_s1) begin
				if (last_s1) begin
					offset_q <= '0;
					etype_q <= '0;
					hw_q <= '0;
					proto_q <= '0;
					src_q <= '0;
					dst_q <= '0;
					ports_q <= '0;
				end else begin
					offset_q <= offset_n;
					etype_q <= etype_n;
					hw_q <= hw_n;
					proto_q <= proto_n;
					src_q <= src_n;
					dst_q <= dst_n;
					ports_q <= ports_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1) begin
			sum_s2.frame_len <= offset_n;
			sum_s2.ether_type <= etype_n;
			sum_s2.header_words <= hw_n;
			sum_s2.ip_proto <= proto_n;
			sum_s2.src_addr <= src_n;
			sum_s2.dst_addr <= dst_n;
			sum_s2.port_bytes <= ports_n;
		end
	end

	assign last_pending = valid_s1 & last_s1;
	assign sum_valid = sum_valid_s2;
	assign sum = sum_s2;

	a_last_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_s1 |-> valid_s1) else $error("last flag without a byte");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |=> offset_q == '0) else $error("frame state not cleared");
	a_sum_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid_s2 |-> $past(valid_s1 && last_s1)) else $error("summary without last byte");

endmodule

FILE: rtl/ihp_count.sv
// Frame classification and 64-bit traffic counters.
// Depends on ihp_pkg; turns a frame summary into one result.
module ihp_count (
	input  logic clk,
	input  logic arst_n,
	input  logic sum_valid,
	input  ihp_pkg::frame_sum_t sum,
	output ihp_pkg::result_t res
);

	logic [63:0] pkts_q, bytes_q, tcp_q, udp_q, icmp_q;
	logic [ihp_pkg::LEN_W-1:0] len;
	logic [ihp_pkg::L4_W-1:0] l4_off;
	logic [ihp_pkg::LEN_W-1:0] l4_pos;
	logic counted, ev, is_tcp, is_udp, is_icmp, ports_ok;
	logic [63:0] pkts_n, bytes_n, tcp_n, udp_n, icmp_n;

	assign len = sum.frame_len;
	assign l4_off = ihp_pkg::L4_BASE + {2'b00, sum.header_words, 2'b00};
	assign l4_pos = {{(ihp_pkg::LEN_W-ihp_pkg::L4_W){1'b0}}, l4_off};

	assign counted = len >= ihp_pkg::ETH_HDR_BYTES;
	assign ev = counted && sum.ether_type == ihp_pkg::ETYPE_IPV4 &&
		len >= ihp_pkg::IPV4_MIN_FRAME && sum.header_words >= ihp_pkg::IHL_MIN &&
		l4_pos <= len;
	assign is_tcp = ev && sum.ip_proto == ihp_pkg::PROTO_TCP;
	assign is_udp = ev && sum.ip_proto == ihp_pkg::PROTO_UDP;
	assign is_icmp = ev && sum.ip_proto == ihp_pkg::PROTO_ICMP;
	// ports only when the whole L4 header fits
	assign ports_ok = (is_tcp &&
			l4_pos + ihp_pkg::LEN_W'(ihp_pkg::TCP_HDR_BYTES) <= len) ||
		(is_udp && l4_pos + ihp_pkg::LEN_W'(ihp_pkg::UDP_HDR_BYTES) <= len);

	assign pkts_n = counted ? pkts_q + 64'd1 : pkts_q;
	assign bytes_n = counted ? bytes_q + {48'd0, len} : bytes_q;
	assign tcp_n = is_tcp ? tcp_q + 64'd1 : tcp_q;
	assign udp_n = is_udp ? udp_q + 64'd1 : udp_q;
	assign icmp_n = is_icmp ? icmp_q + 64'd1 : icmp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkts_q <= '0;
			bytes_q <= '0;
			tcp_q <= '0;
			udp_q <= '0;
			icmp_q <= '0;
		end else if (sum_valid) begin
			pkts_q <= pkts_n;
			bytes_q <= bytes_n;
			tcp_q <= tcp_n;
			udp_q <= udp_n;
			icmp_q <= icmp_n;
		end
	end

	always_comb begin
		res.event_valid = ev;
		res.src_ip = ev ? sum.src_addr : 32'd0;
		res.dst_ip = ev ? sum.dst_addr : 32'd0;
		res.sport = ports_ok ? sum.port_bytes[31:16] : 16'd0;
		res.dport = ports_ok ? sum.port_bytes[15:0] : 16'd0;
		res.protocol = ev ? sum.ip_proto : 8'd0;
		res.pkt_len = len;
		res.pkt_total = pkts_n;
		res.byte_total = bytes_n;
		res.tcp_total = tcp_n;
		res.udp_total = udp_n;
		res.icmp_total = icmp_n;
	end

	a_ev_long_enough: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && res.event_valid |-> res.pkt_len >= ihp_pkg::IPV4_MIN_FRAME)
		else $error("event on a short frame");
	a_short_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && len < ihp_pkg::ETH_HDR_BYTES |=> $stable(pkts_q) && $stable(bytes_q))
		else $error("short frame counted");
	a_ports_need_event: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && !res.event_valid |-> res.sport == 16'd0 && res.dport == 16'd0 &&
		res.src_ip == 32'd0) else $error("fields set without event");

endmodule

FILE: rtl/ihp_out_fifo.sv
// Small result queue between the counter stage and the output channel.
// Depends on ihp_pkg; a register file of OUT_DEPTH result entries.
module ihp_out_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ihp_pkg::result_t push_data,
	input  logic pop,
	output logic not_empty,
	output ihp_pkg::result_t head,
	output logic [ihp_pkg::OUT_CNT_W-1:0] count
);

	ihp_pkg::result_t entry_q [ihp_pkg::OUT_DEPTH];
	logic [ihp_pkg::OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ihp_pkg::OUT_CNT_W-1:0] count_q;
	logic do_pop;

	assign do_pop = pop && count_q != '0;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign not_empty = count_q != '0;
	assign head = entry_q[rd_ptr_q];
	assign count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < ihp_pkg::OUT_CNT_W'(ihp_pkg::OUT_DEPTH) || do_pop)
		else $error("result queue overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ihp_pkg::OUT_CNT_W'(ihp_pkg::OUT_DEPTH)) else $error("count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q) else $error("pointers disagree with count");

endmodule

FILE: rtl/ipv4_header_probe_with_counters.sv
// Top level of the IPv4 header probe with traffic counters.
// Depends on ihp_pkg, ihp_capture, ihp_count and ihp_out_fifo.
//
//   channel  | dir | handshake          | payload
//   s_axis   | in  | tvalid / tready    | tdata: pkt_byte; tlast: last_byte
//   m_axis   | out | tvalid / tready    | tuser: event_valid; tdata: other result fields
//
// One byte is taken every clock while tready is high. A frame's result
// leaves the queue after its final byte passes the input register,
// capture, and counter update into the result queue.
// Reset clears all frame state, counters and the queue.
// tready drops only when the four-entry result queue plus results still
// in the pipeline could fill it; a stall on the output never loses a result.
module ipv4_header_probe_with_counters (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] pkt_byte
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic m_axis_tuser,         // [0] event_valid
	// [31:0] src_ip, [63:32] dst_ip, [79:64] sport, [95:80] dport,
	// [103:96] protocol, [119:104] pkt_len, [183:120] pkt_total,
	// [247:184] byte_total, [311:248] tcp_total, [375:312] udp_total,
	// [439:376] icmp_total
	output logic [ihp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic in_req;
	logic last_pending;
	logic sum_valid;
	ihp_pkg::frame_sum_t sum;
	ihp_pkg::result_t res;
	ihp_pkg::result_t head;
	logic not_empty;
	logic [ihp_pkg::OUT_CNT_W-1:0] q_count;
	logic [ihp_pkg::OUT_CNT_W-1:0] committed;

	assign in_req = s_axis_tvalid & s_axis_tready;

	// queue slots already promised to results still in flight
	assign committed = q_count + ihp_pkg::OUT_CNT_W'(last_pending) +
		ihp_pkg::OUT_CNT_W'(sum_valid);
	assign s_axis_tready = committed < ihp_pkg::OUT_CNT_W'(ihp_pkg::OUT_DEPTH);

	ihp_capture u_capture (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_req),
		.in_byte(s_axis_tdata),
		.in_last(s_axis_tlast),
		.last_pending(last_pending),
		.sum_valid(sum_valid),
		.sum(sum)
	);

	ihp_count u_count (
		.clk(clk),
		.arst_n(arst_n),
		.sum_valid(sum_valid),
		.sum(sum),
		.res(res)
	);

	ihp_out_fifo u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(sum_valid),
		.push_data(res),
		.pop(m_axis_tready),
		.not_empty(not_empty),
		.head(head),
		.count(q_count)
	);

	assign m_axis_tvalid = not_empty;
	assign m_axis_tuser = head.event_valid;
	assign m_axis_tdata = ihp_pkg::OUT_TDATA_W'(head[ihp_pkg::RESULT_W-1:1]);

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for ipv4_header_probe_with_counters: byte-wise frames in,
// one result per frame out, checked against an in-bench parser model.
// Depends on rtl/ihp_pkg.sv and the RTL under rtl/.
module tb;

	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [15:0] ETYPE_SWAPPED = 16'h0008;
	localparam int unsigned IDLE_PCT = 23;
	localparam int unsigned RAND_BYTES = 960;
	localparam int unsigned RAND_FRAMES = 16;
	localparam int unsigned N_DIRECTED = 18;
	localparam longint unsigned TIMEOUT_NS = 64'd30_000_000;

	typedef struct packed {
		logic [31:0] len;
		logic [15:0] etype;
		logic [3:0] ihl;
		logic [7:0] proto;
		bit typed;
		bit exp_valid;
		logic [15:0] exp_len;
		logic [63:0] exp_pkts;
	} frame_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic m_axis_tuser;
	logic [ihp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	// parser model state
	int unsigned frame_pos;
	logic [15:0] seen_etype;
	logic [3:0] seen_ihl;
	logic [7:0] seen_proto;
	logic [31:0] seen_src;
	logic [31:0] seen_dst;
	logic [31:0] seen_ports;
	logic [63:0] n_frames;
	logic [63:0] n_bytes;
	logic [63:0] n_tcp;
	logic [63:0] n_udp;
	logic [63:0] n_icmp;

	ihp_pkg::result_t pending_results[$];
	int unsigned mismatches = 0;
	frame_row_t pinned = '0;
	bit in_random = 1'b0;
	bit calm = 1'b0;
	int unsigned rand_bytes = 0;

	string field_name [12] = '{"event_valid", "src_ip", "dst_ip", "sport", "dport",
		"protocol", "pkt_len", "pkt_total", "byte_total", "tcp_total", "udp_total",
		"icmp_total"};

	// len, etype, ihl, proto, typed, exp_valid, exp_len, exp_pkts
	frame_row_t directed_frames [N_DIRECTED] = '{
		'{32'd1, ihp_pkg::ETYPE_IPV4, 4'd5, ihp_pkg::PROTO_TCP, 1'b1, 1'b0, 16'd1, 64'd0},
		'{32'd13, ihp_pkg::ETYPE_IPV4, 4'd5, ihp_pkg::PROTO_TCP, 1'b1, 1'b0, 16'd13, 64'd0},
		'{32'd14, ihp_pkg::ETYPE_IPV4, 4'd5, ihp_pkg::PROTO_TCP, 1'b1, 1'b0, 16'd14, 64'd1},
		'{32'd33, ihp_pkg::ETYPE_IPV4, 4'd5, ihp_pkg::PROTO_TCP, 1'b1, 1'b0, 16'd33, 64'd2},
		'{32'd34, ihp_pkg::ETYPE_IPV4, 4'd5, ihp_pkg::PROTO_ICMP, 1'b1, 1'b1, 16'd34, 64'd3},
		'{32'd60, ETYPE_IPV6, 4'd5, ihp_pkg::PROTO_TCP, 1'b1, 1'b0, 16'd60, 64'd4},
		'{32'd60, ihp_pkg::ETYPE_IPV4, 4'd0, ihp_pkg::PROTO_TCP, 1'b1, 1'b0, 16'd60, 64'd5},
		'{32'd60, ihp_pkg::ETYPE_IPV4, 4'd4, ihp_pkg::PROTO_UDP, 1'b1, 1'b0, 16'd60, 64'd6},
		'{32'd73, ihp_pkg::ETYPE_IPV4, 4'd15, ihp_pkg::PROTO_TCP, 1'b1, 1'b0, 16'd73, 64'd7},
		'{32'd74, ihp_pkg::ETYPE_IPV4, 4'd15, ihp_pkg::PROTO_TCP, 1'b1, 1'b1, 16'd74, 64'd8},
		'{32'd53, ihp_pkg::ETYPE_IPV4, 4'd5, ihp_pkg::PROTO_TCP, 1'b0, 1'b0, 16'd0, 64'd0},
		'{32'd54, ihp_pkg::ETYPE_IPV4, 4'd5, ihp_pkg::PROTO_TCP, 1'b0, 1'b0, 16'd0, 64'd0},
		'{32'd41, ihp_pkg::ETYPE_IPV4, 4'd5, ihp_pkg::PROTO_UDP, 1'b0, 1'b0, 16'd0, 64'd0},
		'{32'd42, ihp_pkg::ETYPE_IPV4, 4'd5, ihp_pkg::PROTO_UDP, 1'b0, 1'b0, 16'd0, 64'd0},
		'{32'd100, ihp_pkg::ETYPE_IPV4, 4'd6, ihp_pkg::PROTO_UDP, 1'b0, 1'b0, 16'd0, 64'd0},
		'{32'd60, ihp_pkg::ETYPE_IPV4, 4'd5, 8'd0, 1'b0, 1'b0, 16'd0, 64'd0},
		'{32'd60, ihp_pkg::ETYPE_IPV4, 4'd5, 8'd255, 1'b0, 1'b0, 16'd0, 64'd0},
		'{32'd60, ETYPE_SWAPPED, 4'd5, ihp_pkg::PROTO_TCP, 1'b0, 1'b0, 16'd0, 64'd0}
	};

	ipv4_header_probe_with_counters dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// advance the parser model by one byte; returns 1 when the frame closes
	function automatic bit probe_byte(input logic [7:0] b, input bit last,
			output ihp_pkg::result_t r);
		int unsigned l4;
		logic [15:0] len;
		r = '0;
		l4 = ihp_pkg::L4_BASE + seen_ihl * 4;
		if (frame_pos < ihp_pkg::MAX_FRAME_BYTES) begin
			if (frame_pos == ihp_pkg::POS_ETYPE_HI || frame_pos == ihp_pkg::POS_ETYPE_LO)
				seen_etype = {seen_etype[7:0], b};
			if (frame_pos == ihp_pkg::POS_IHL)
				seen_ihl = b[3:0];
			if (frame_pos == ihp_pkg::POS_PROTO)
				seen_proto = b;
			if (frame_pos >= ihp_pkg::POS_SRC_FIRST && frame_pos <= ihp_pkg::POS_SRC_LAST)
				seen_src = {seen_src[23:0], b};
			if (frame_pos >= ihp_pkg::POS_DST_FIRST && frame_pos <= ihp_pkg::POS_DST_LAST)
				seen_dst = {seen_dst[23:0], b};
			if (frame_pos >= ihp_pkg::POS_L4_MIN && frame_pos >= l4 &&
					frame_pos < l4 + ihp_pkg::PORT_BYTES)
				seen_ports = {seen_ports[23:0], b};
			frame_pos++;
		end
		if (!last)
			return 1'b0;

		len = frame_pos[15:0];
		l4 = ihp_pkg::L4_BASE + seen_ihl * 4;
		if (len >= ihp_pkg::ETH_HDR_BYTES) begin
			n_frames++;
			n_bytes += len;
			if (seen_etype == ihp_pkg::ETYPE_IPV4 && len >= ihp_pkg::IPV4_MIN_FRAME &&
					seen_ihl >= ihp_pkg::IHL_MIN && l4 <= len) begin
				r.event_valid = 1'b1;
				r.src_ip = seen_src;
				r.dst_ip = seen_dst;
				r.protocol = seen_proto;
				if (seen_proto == ihp_pkg::PROTO_TCP) begin
					if (l4 + ihp_pkg::TCP_HDR_BYTES <= len)
						{r.sport, r.dport} = seen_ports;
					n_tcp++;
				end else if (seen_proto == ihp_pkg::PROTO_UDP) begin
					if (l4 + ihp_pkg::UDP_HDR_BYTES <= len)
						{r.sport, r.dport} = seen_ports;
					n_udp++;
				end else if (seen_proto == ihp_pkg::PROTO_ICMP) begin
					n_icmp++;
				end
			end
		end
		r.pkt_len = len;
		r.pkt_total = n_frames;
		r.byte_total = n_bytes;
		r.tcp_total = n_tcp;
		r.udp_total = n_udp;
		r.icmp_total = n_icmp;

		frame_pos = 0;
		seen_etype = '0;
		seen_ihl = '0;
		seen_proto = '0;
		seen_src = '0;
		seen_dst = '0;
		seen_ports = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	// header fields are forced unless raw; every other byte is random
	task automatic send_frame(input int unsigned len, input logic [15:0] etype,
			input logic [3:0] ihl, input logic [7:0] proto, input bit raw);
		logic [7:0] b;
		bit last;
		ihp_pkg::result_t res;
		for (int unsigned pos = 0; pos < len; pos++) begin
			b = 8'($urandom);
			last = (pos == len - 1);
			if (!raw) begin
				if (pos == ihp_pkg::POS_ETYPE_HI)
					b = etype[15:8];
				else if (pos == ihp_pkg::POS_ETYPE_LO)
					b = etype[7:0];
				else if (pos == ihp_pkg::POS_IHL)
					b[3:0] = ihl;
				else if (pos == ihp_pkg::POS_PROTO)
					b = proto;
			end
			@(negedge clk);
			while (!calm && $urandom_range(99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= b;
			s_axis_tlast <= last;
			// hold the request until tready
			@(posedge clk);
			while (!s_axis_tready)
				@(posedge clk);
			if (probe_byte(b, last, res)) begin
				if (pinned.typed) begin
					res.event_valid = pinned.exp_valid;
					res.pkt_len = pinned.exp_len;
					res.pkt_total = pinned.exp_pkts;
				end
				pending_results.push_back(res);
			end
			if (in_random) begin
				rand_bytes++;
				calm = rand_bytes >= 300 && rand_bytes < 650;
			end
		end
	endtask

	always @(negedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		ihp_pkg::result_t got;
		ihp_pkg::result_t want;
		logic [63:0] got_f [12];
		logic [63:0] want_f [12];
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = ihp_pkg::result_t'({m_axis_tdata[ihp_pkg::RESULT_W-2:0], m_axis_tuser});
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 64'd1, 64'd0);
			end else begin
				want = pending_results.pop_front();
				got_f = '{got.event_valid, got.src_ip, got.dst_ip, got.sport,
					got.dport, got.protocol, got.pkt_len, got.pkt_total,
					got.byte_total, got.tcp_total, got.udp_total, got.icmp_total};
				want_f = '{want.event_valid, want.src_ip, want.dst_ip, want.sport,
					want.dport, want.protocol, want.pkt_len, want.pkt_total,
					want.byte_total, want.tcp_total, want.udp_total, want.icmp_total};
				for (int i = 0; i < 12; i++)
					if (got_f[i] !== want_f[i])
						report_mismatch(field_name[i], got_f[i], want_f[i]);
			end
		end
	end

	initial begin
		int unsigned pick;
		int unsigned len;
		int unsigned l4;
		int unsigned rand_frames;
		logic [15:0] etype;
		logic [3:0] ihl;
		logic [7:0] proto;
		bit raw;

		frame_pos = 0;
		seen_etype = '0;
		seen_ihl = '0;
		seen_proto = '0;
		seen_src = '0;
		seen_dst = '0;
		seen_ports = '0;
		n_frames = '0;
		n_bytes = '0;
		n_tcp = '0;
		n_udp = '0;
		n_icmp = '0;
		rand_frames = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			pinned = directed_frames[i];
			send_frame(directed_frames[i].len, directed_frames[i].etype,
				directed_frames[i].ihl, directed_frames[i].proto, 1'b0);
		end
		pinned = '0;

		// mostly well-formed IPv4 frames, some noise and broken headers
		in_random = 1'b1;
		while (rand_bytes < RAND_BYTES || rand_frames < RAND_FRAMES) begin
			pick = $urandom_range(99);
			etype = ihp_pkg::ETYPE_IPV4;
			ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : ihp_pkg::IHL_MIN;
			raw = 1'b0;
			case ($urandom_range(9)) inside
				[0:2]: proto = ihp_pkg::PROTO_TCP;
				[3:5]: proto = ihp_pkg::PROTO_UDP;
				[6:7]: proto = ihp_pkg::PROTO_ICMP;
				default: proto = 8'($urandom);
			endcase
			l4 = ihp_pkg::L4_BASE + ihl * 4;
			len = l4 + $urandom_range(28);
			if (pick < 8) begin
				raw = 1'b1;
				len = $urandom_range(60, 1);
			end else if (pick < 16) begin
				len = $urandom_range(33, 1);
			end else if (pick < 22) begin
				etype = 16'($urandom);
			end else if (pick < 30) begin
				ihl = 4'($urandom_range(4));
				len = $urandom_range(80, 34);
			end else if (pick < 36) begin
				len = $urandom_range(l4 + 2, 34);
			end
			send_frame(len, etype, ihl, proto, raw);
			rand_frames++;
		end
		calm = 1'b0;

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule
